// ===== design/post_code_history_monitor_top_assert.svh =====
// Assertion macros shared by the history monitor RTL.
// No dependencies; clk and rst are taken from the including module's scope.
`ifndef POST_CODE_HISTORY_MONITOR_TOP_ASSERT_SVH
`define POST_CODE_HISTORY_MONITOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define PCHM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PCHM_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);
`else
`define PCHM_ASSERT(lbl, prop, msg)
`define PCHM_ASSERT_NEXT(lbl, cond, expr, msg)
`endif
`endif

// ===== design/pchm_pkg.sv =====
// Package for the POST code history monitor: sizes, action codes, item types.
// No dependencies.
package pchm_pkg;

  localparam int HIST_DEPTH  = 8192;
  localparam int HIST_AW     = $clog2(HIST_DEPTH);
  localparam int COUNT_W     = HIST_AW + 1;
  localparam int CODE_W      = 8;
  localparam int TIMEOUT_W   = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CODE_W-1:0]    CODE_RESET    = 8'hff;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd20;
  localparam logic [TIMEOUT_W-1:0] SECONDS_MAX   = 8'hff;

  typedef enum logic [1:0] {
    ACT_CODE  = 2'd0,
    ACT_POWER = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [CODE_W-1:0]   code;
    logic                power_good_5v;
    logic                power_good_12v;
    logic [HIST_AW-1:0]  read_index;
  } item_t;

  typedef struct packed {
    logic [CODE_W-1:0]   read_data;
    logic                read_valid;
    logic [COUNT_W-1:0]  stored_count;
    logic                finished;
    logic                recorded;
    logic                cleared;
    logic                archive_event;
  } result_t;

  // Work handed from the front end to the history memory side.
  typedef struct packed {
    logic                we;
    logic [HIST_AW-1:0]  addr;
    logic [CODE_W-1:0]   wdata;
    result_t             res;
  } mem_op_t;

endpackage

// ===== design/post_code_history_monitor_top.sv =====
// POST code history monitor. The front end commits state and queues the op at the accept
// edge, then the history RAM access registers the result once the result slot is free.
// Throughput: 1 request per cycle, one op per cycle into the single-port history RAM;
// a held result stalls the RAM side and intake stops once the 2-entry op queue fills.
// Reset (rst, synchronous, active high) clears all control state and sets the timeout
// register to 20; the history RAM is not cleared, unwritten entries are never read.
//
// Depends on pchm_pkg, pchm_front, pchm_queue, pchm_back.
module post_code_history_monitor_top (
  input  logic                            clk,
  input  logic                            rst,
  // request side
  input  logic                            push,
  output logic                            full,
  input  pchm_pkg::item_t                 item,
  // result side
  output logic                            empty,
  input  logic                            pop,
  output pchm_pkg::result_t               result,
  // finish timeout register
  input  logic                            cfg_we,
  input  logic [pchm_pkg::TIMEOUT_W-1:0]  cfg_wdata
);
  import pchm_pkg::*;

  mem_op_t front_op, back_op;
  logic    accept;
  logic    q_empty, q_pop;

  // A request is taken whenever the op queue has room; the front end
  // commits all state in that same cycle, so back-to-back requests see
  // each other's effects without waiting on the RAM.
  assign accept = push && !full;

  pchm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .item      (item),
    .op        (front_op)
  );

  // Ops run in order, so a read always follows every earlier write.
  pchm_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (accept),
    .op_in  (front_op),
    .full   (full),
    .pop    (q_pop),
    .op_out (back_op),
    .empty  (q_empty)
  );

  // RAM access and the result register; a result held by pop stalls it, and
  // the op queue holds up to two requests before full rises.
  pchm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (!q_empty),
    .op       (back_op),
    .op_take  (q_pop),
    .result   (result),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

// ===== design/pchm_front.sv =====
// Front end: takes each request, updates the monitor state and forms one memory op.
// Depends on pchm_pkg and the assertion macro header.
`include "post_code_history_monitor_top_assert.svh"

module pchm_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pchm_pkg::TIMEOUT_W-1:0]   cfg_wdata,
  input  logic                             accept,
  input  pchm_pkg::item_t                  item,
  output pchm_pkg::mem_op_t                op
);
  import pchm_pkg::*;

  localparam logic [COUNT_W:0]   DEPTH_EXT = (COUNT_W + 1)'(HIST_DEPTH);
  localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(HIST_DEPTH);
  localparam logic [HIST_AW-1:0] LAST_PTR  = HIST_AW'(HIST_DEPTH - 1);

  logic [TIMEOUT_W-1:0] timeout;
  logic [HIST_AW-1:0]   wp, wp_next;
  logic [COUNT_W-1:0]   count, count_next;
  logic [CODE_W-1:0]    prev_code, prev_code_next;
  logic                 done, done_next;
  logic                 running, running_next;
  logic [TIMEOUT_W-1:0] seconds, seconds_next;
  logic                 prev_power, prev_power_next;

  logic                 clear, append, now_on;
  logic [TIMEOUT_W-1:0] sec_inc;
  logic [HIST_AW-1:0]   wp_c;
  logic [COUNT_W-1:0]   cnt_c;
  logic [COUNT_W:0]     rd_sum;

  // oldest entry sits at wp - count; one conditional subtract wraps it
  always_comb begin
    rd_sum = {2'b00, wp} + DEPTH_EXT - {1'b0, count} + {2'b00, item.read_index};
    if (rd_sum >= DEPTH_EXT) begin
      rd_sum = rd_sum - DEPTH_EXT;
    end
  end

  always_comb begin
    prev_code_next  = prev_code;
    done_next       = done;
    running_next    = running;
    seconds_next    = seconds;
    prev_power_next = prev_power;
    clear           = 1'b0;
    append          = 1'b0;
    now_on          = item.power_good_5v & item.power_good_12v;
    sec_inc         = (seconds != SECONDS_MAX) ? seconds + 1'b1 : seconds;
    op              = '0;

    unique case (item.action)
      ACT_CODE: begin
        if (item.code == '0) begin
          if (!running) begin
            running_next = 1'b1;
            seconds_next = '0;
          end
        end else begin
          running_next = 1'b0;
          seconds_next = '0;
        end
        if (item.code != prev_code) begin
          prev_code_next = item.code;
          if (!done || item.code != '0) begin
            // nonzero code after finish is a warm reset
            if (done) begin
              done_next = 1'b0;
              clear     = 1'b1;
            end
            append = 1'b1;
          end
        end
      end
      ACT_POWER: begin
        if (now_on && !prev_power) begin
          done_next = 1'b0;
          clear     = 1'b1;
        end
        prev_power_next = now_on;
      end
      ACT_TICK: begin
        if (running && !done) begin
          seconds_next = sec_inc;
          if (sec_inc >= timeout) begin
            done_next            = 1'b1;
            running_next         = 1'b0;
            seconds_next         = '0;
            op.res.archive_event = (count != '0);
          end
        end
      end
      ACT_READ: begin
        op.res.read_valid = ({1'b0, item.read_index} < count);
        op.addr           = rd_sum[HIST_AW-1:0];
      end
      default: ;
    endcase

    wp_c  = clear ? '0 : wp;
    cnt_c = clear ? '0 : count;
    if (append) begin
      op.we      = 1'b1;
      op.addr    = wp_c;
      op.wdata   = item.code;
      wp_next    = (wp_c == LAST_PTR) ? '0 : wp_c + 1'b1;
      count_next = (cnt_c == DEPTH_CNT) ? cnt_c : cnt_c + 1'b1;
    end else begin
      wp_next    = wp_c;
      count_next = cnt_c;
    end

    op.res.stored_count = count_next;
    op.res.finished     = done_next;
    op.res.recorded     = append;
    op.res.cleared      = clear;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      count      <= '0;
      prev_code  <= CODE_RESET;
      done       <= 1'b0;
      running    <= 1'b0;
      seconds    <= '0;
      prev_power <= 1'b0;
    end else if (accept) begin
      wp         <= wp_next;
      count      <= count_next;
      prev_code  <= prev_code_next;
      done       <= done_next;
      running    <= running_next;
      seconds    <= seconds_next;
      prev_power <= prev_power_next;
    end
  end

  `PCHM_ASSERT(a_count_bound, count <= DEPTH_CNT, "history count above depth")
  `PCHM_ASSERT_NEXT(a_clear_count, accept && op.res.cleared, count <= 1, "count not reset by clear")
  `PCHM_ASSERT_NEXT(a_append_count, accept && op.we && !op.res.cleared, count != '0, "append left empty history")

endmodule

// ===== design/pchm_queue.sv =====
// Short FIFO of memory ops between the front end and the memory side.
// Depends on pchm_pkg and the assertion macro header.
`include "post_code_history_monitor_top_assert.svh"

module pchm_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pchm_pkg::mem_op_t  op_in,
  output logic               full,
  input  logic               pop,
  output pchm_pkg::mem_op_t  op_out,
  output logic               empty
);
  import pchm_pkg::*;

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QAW-1:0] QLAST = QAW'(QUEUE_DEPTH - 1);
  localparam logic [QCW-1:0] QFULL = QCW'(QUEUE_DEPTH);

  mem_op_t        slots [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QCW-1:0] count;
  logic           do_push, do_pop;

  assign full    = (count == QFULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign op_out  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QLAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QLAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `PCHM_ASSERT(a_q_bound, count <= QFULL, "queue count above depth")

endmodule

// ===== design/pchm_back.sv =====
// Memory side: history RAM, registered read data and the result register.
// Depends on pchm_pkg and the assertion macro header.
`include "post_code_history_monitor_top_assert.svh"

module pchm_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                op_valid,
  input  pchm_pkg::mem_op_t   op,
  output logic                op_take,
  output pchm_pkg::result_t   result,
  output logic                empty,
  input  logic                pop
);
  import pchm_pkg::*;

  logic [CODE_W-1:0] hist_mem [HIST_DEPTH];
  logic [CODE_W-1:0] rdata_q;
  result_t           res_q;
  logic              out_valid;

  // issue only when the result slot is free or drains this cycle
  assign op_take = op_valid && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (op_take) begin
      if (op.we) begin
        hist_mem[op.addr] <= op.wdata;
      end
      rdata_q <= hist_mem[op.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (op_take) begin
      res_q <= op.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    result           = res_q;
    result.read_data = res_q.read_valid ? rdata_q : '0;
  end

  assign empty = !out_valid;

  `PCHM_ASSERT_NEXT(a_hold_rdata, out_valid && !pop, $stable(rdata_q), "read data moved while stalled")

endmodule

// ===== tb/post_code_history_monitor_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for post_code_history_monitor_top: queued requests, randomized idling,
// in-bench prediction of every report. Depends on pchm_pkg and the monitor RTL.
module post_code_history_monitor_top_tb;
  import pchm_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  item_t item = '0;
  logic empty;
  logic pop = 1'b0;
  result_t result;
  logic cfg_we = 1'b0;
  logic [TIMEOUT_W-1:0] cfg_wdata = '0;

  post_code_history_monitor_top uut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Requests waiting to be sent, and reports predicted but not yet popped.
  item_t boot_events[$];
  result_t due_reports[$];

  // Shadow of the monitor state, updated as each request is accepted.
  logic [CODE_W-1:0] code_hist [HIST_DEPTH];
  logic [HIST_AW-1:0] hist_wr = '0;
  logic [COUNT_W-1:0] hist_count = '0;
  logic [CODE_W-1:0] last_code = CODE_RESET;
  logic shadow_done = 1'b0;
  logic zero_timer_on = 1'b0;
  logic [TIMEOUT_W-1:0] zero_secs = '0;
  logic power_was_on = 1'b0;
  logic [TIMEOUT_W-1:0] finish_timeout = TIMEOUT_RESET;

  int mismatches = 0;
  int reports_seen = 0;
  int send_wait = 0;
  int send_calm = 0;
  int recv_wait = 0;
  int recv_calm = 0;
  int quiet_cycles = 0;
  logic [CODE_W-1:0] gen_last = CODE_RESET;

  function automatic void wipe_history();
    hist_wr = '0;
    hist_count = '0;
  endfunction

  function automatic void store_code(logic [CODE_W-1:0] c);
    code_hist[hist_wr] = c;
    hist_wr = hist_wr + 1'b1;
    if (hist_count < HIST_DEPTH) hist_count = hist_count + 1'b1;
  endfunction

  // Applies one request to the shadow state and returns the report it yields.
  function automatic result_t predict_report(item_t it);
    result_t r;
    logic [HIST_AW-1:0] pos;
    r = '0;
    case (it.action)
      ACT_CODE: begin
        // timer bookkeeping happens ahead of the repeat filter
        if (it.code == '0) begin
          if (!zero_timer_on) begin
            zero_timer_on = 1'b1;
            zero_secs = '0;
          end
        end else begin
          zero_timer_on = 1'b0;
          zero_secs = '0;
        end
        if (it.code != last_code) begin
          last_code = it.code;
          if (!shadow_done) begin
            store_code(it.code);
            r.recorded = 1'b1;
          end else if (it.code != '0) begin
            // warm reset
            shadow_done = 1'b0;
            wipe_history();
            r.cleared = 1'b1;
            store_code(it.code);
            r.recorded = 1'b1;
          end
        end
      end
      ACT_POWER: begin
        if (it.power_good_5v && it.power_good_12v && !power_was_on) begin
          shadow_done = 1'b0;
          wipe_history();
          r.cleared = 1'b1;
        end
        power_was_on = it.power_good_5v && it.power_good_12v;
      end
      ACT_TICK: begin
        if (zero_timer_on && !shadow_done) begin
          if (zero_secs != SECONDS_MAX) zero_secs = zero_secs + 1'b1;
          if (zero_secs >= finish_timeout) begin
            shadow_done = 1'b1;
            r.archive_event = (hist_count != '0);
            zero_timer_on = 1'b0;
            zero_secs = '0;
          end
        end
      end
      default: begin
        if (it.read_index < hist_count) begin
          // oldest entry sits count places behind the write pointer
          pos = hist_wr - hist_count[HIST_AW-1:0] + it.read_index;
          r.read_data = code_hist[pos];
          r.read_valid = 1'b1;
        end
      end
    endcase
    r.stored_count = hist_count;
    r.finished = shadow_done;
    return r;
  endfunction

  // Idle cycles before the next request or pop; now and then a run with none at all.
  function automatic int draw_gap(ref int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic void queue_item(action_t a, logic [CODE_W-1:0] c, logic p5, logic p12,
                                     logic [HIST_AW-1:0] idx);
    item_t it;
    it.action = a;
    it.code = c;
    it.power_good_5v = p5;
    it.power_good_12v = p12;
    it.read_index = idx;
    boot_events.push_back(it);
    if (a == ACT_CODE) gen_last = c;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("report %0d: %s expected 0x%0h, got 0x%0h", reports_seen, name, want, got);
    end
  endtask

  // Request driver: holds a request until accepted, then idles for a drawn gap.
  always @(posedge clk) begin : drive_requests
    logic held;
    if (rst) begin
      push <= 1'b0;
    end else begin
      held = push && full;
      if (push && !full) begin
        due_reports.push_back(predict_report(item));
        send_wait = draw_gap(send_calm);
      end
      if (!held) begin
        if (send_wait > 0) begin
          send_wait--;
          push <= 1'b0;
        end else if (boot_events.size() > 0) begin
          item <= boot_events.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Report collector: checks each popped report against the oldest prediction.
  always @(posedge clk) begin : collect_reports
    result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        reports_seen++;
        if (due_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("report %0d arrived with nothing predicted: 0x%0h", reports_seen, result);
        end else begin
          want = due_reports.pop_front();
          check_field("read_data", 16'(want.read_data), 16'(result.read_data));
          check_field("read_valid", 16'(want.read_valid), 16'(result.read_valid));
          check_field("stored_count", 16'(want.stored_count), 16'(result.stored_count));
          check_field("finished", 16'(want.finished), 16'(result.finished));
          check_field("recorded", 16'(want.recorded), 16'(result.recorded));
          check_field("cleared", 16'(want.cleared), 16'(result.cleared));
          check_field("archive_event", 16'(want.archive_event), 16'(result.archive_event));
        end
        recv_wait = draw_gap(recv_calm);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: too long without a request or report moving means a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("no handshake for %0d cycles, %0d reports still due",
                 WATCHDOG_LIMIT, due_reports.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Blocks until every queued request is sent and every report popped, plus slack.
  task automatic wait_idle();
    do @(negedge clk);
    while (boot_events.size() != 0 || push || due_reports.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Timeout writes only happen with the monitor drained.
  task automatic set_timeout(logic [TIMEOUT_W-1:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    finish_timeout = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly boot-shaped sequences: codes, a zero, enough ticks to finish
  // (sometimes not), reads, then a power cycle, a late zero or neither; the rest is noise.
  task automatic random_phase(int n, int tmo);
    int goal;
    int ticks;
    goal = boot_events.size() + n;
    while (boot_events.size() < goal) begin
      if ($urandom_range(0, 9) < 7) begin
        repeat ($urandom_range(1, 20)) begin
          if ($urandom_range(0, 9) == 0) queue_item(ACT_CODE, gen_last, 0, 0, 0);
          else queue_item(ACT_CODE, CODE_W'($urandom_range(1, 255)), 0, 0, 0);
          if ($urandom_range(0, 5) == 0)
            queue_item(ACT_READ, 0, 0, 0, HIST_AW'($urandom_range(0, 24)));
        end
        repeat ($urandom_range(1, 2)) queue_item(ACT_CODE, 0, 0, 0, 0);
        if ($urandom_range(0, 3) == 0) ticks = $urandom_range(0, tmo);
        else ticks = tmo + $urandom_range(0, 3);
        repeat (ticks) begin
          queue_item(ACT_TICK, 0, 0, 0, 0);
          if ($urandom_range(0, 15) == 0)
            queue_item(ACT_READ, 0, 0, 0, HIST_AW'($urandom_range(0, 24)));
          if ($urandom_range(0, 40) == 0) queue_item(ACT_CODE, 0, 0, 0, 0);
        end
        repeat ($urandom_range(0, 4))
          queue_item(ACT_READ, 0, 0, 0, HIST_AW'($urandom_range(0, 24)));
        case ($urandom_range(0, 2))
          0: queue_item(ACT_CODE, 0, 0, 0, 0);
          1: begin
            queue_item(ACT_POWER, 0, 1'($urandom_range(0, 1)), 0, 0);
            queue_item(ACT_POWER, 0, 1, 1, 0);
          end
          default: ;
        endcase
      end else begin
        repeat ($urandom_range(1, 10)) begin
          queue_item(action_t'($urandom_range(0, 3)), CODE_W'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     ($urandom_range(0, 1) == 1) ? HIST_AW'($urandom_range(0, 31))
                                                 : HIST_AW'($urandom_range(0, 8191)));
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [CODE_W-1:0] c;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty reads, repeats, timer, finish, warm reset, power-on.
    set_timeout(8'd2);
    queue_item(ACT_READ, 0, 0, 0, 0);            // empty history
    queue_item(ACT_READ, 8'hff, 1, 1, 13'h1fff); // top index, empty
    queue_item(ACT_CODE, 8'hff, 0, 0, 0);        // same as reset value: dropped
    queue_item(ACT_CODE, 8'h01, 0, 0, 0);
    queue_item(ACT_CODE, 8'h80, 0, 0, 0);
    queue_item(ACT_CODE, 8'h00, 0, 0, 0);        // timer starts, code kept
    queue_item(ACT_CODE, 8'h00, 0, 0, 0);        // repeat, timer keeps running
    queue_item(ACT_TICK, 0, 0, 0, 0);
    queue_item(ACT_TICK, 0, 0, 0, 0);            // finish with archive
    queue_item(ACT_TICK, 0, 0, 0, 0);            // finished: no count
    queue_item(ACT_CODE, 8'h00, 0, 0, 0);        // zero after finish
    queue_item(ACT_READ, 0, 0, 0, 13'd2);
    queue_item(ACT_READ, 0, 0, 0, 13'd3);        // one past the end
    queue_item(ACT_CODE, 8'h55, 0, 0, 0);        // warm reset
    queue_item(ACT_CODE, 8'h55, 0, 0, 0);
    queue_item(ACT_CODE, 8'haa, 0, 0, 0);
    queue_item(ACT_POWER, 0, 1, 0, 0);
    queue_item(ACT_POWER, 0, 0, 1, 0);
    queue_item(ACT_POWER, 0, 1, 1, 0);           // power-on clears
    queue_item(ACT_POWER, 0, 1, 1, 0);           // still on: nothing
    queue_item(ACT_CODE, 8'h00, 0, 0, 0);
    queue_item(ACT_TICK, 0, 0, 0, 0);
    queue_item(ACT_POWER, 0, 0, 0, 0);
    queue_item(ACT_TICK, 0, 0, 0, 0);            // finishes; power-off left timer alone
    queue_item(ACT_READ, 0, 0, 0, 0);

    set_timeout(8'd1);
    random_phase(300, 1);
    set_timeout(8'd255);
    random_phase(500, 255);

    set_timeout(TIMEOUT_RESET);
    random_phase(150, 20);

    repeat (3) begin
      c = CODE_W'($urandom_range(3, 30));
      set_timeout(c);
      random_phase(170, int'(c));
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
